>>> rtl/core/quaternion_arithmetic_unit_defines.svh
// Assertion macros shared by the quaternion arithmetic unit RTL
`ifndef QUATERNION_ARITHMETIC_UNIT_DEFINES_SVH
`define QUATERNION_ARITHMETIC_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define QAU_ASSERT_IMPL(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);
`define QAU_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define QAU_ASSERT_IMPL(lbl, clk, rst_n, pre, post, msg)
`define QAU_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif

`endif

>>> rtl/core/qau_pkg.sv
// Types, constants and saturation helpers for the quaternion arithmetic unit
package qau_pkg;

	localparam int DATA_W      = 32;
	localparam int FRAC_BITS   = 24;
	localparam int TWICE_SHIFT = 23;
	localparam int FULL_W      = 2 * DATA_W;
	localparam int PROD_W      = FULL_W - TWICE_SHIFT;
	localparam int ADD_W       = DATA_W + 1;
	localparam int SUM_W       = PROD_W + 3;
	localparam int N_PROD      = 16;
	localparam int N_BASIS     = 9;
	localparam int N_COMP      = 4;
	localparam int N_VEC       = 3;

	typedef enum logic [1:0] {
		FUNC_MUL = 2'd0,
		FUNC_ROT = 2'd1,
		FUNC_ADD = 2'd2,
		FUNC_SUB = 2'd3
	} func_t;

	typedef logic signed [DATA_W-1:0] word_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [ADD_W-1:0]  add_t;
	typedef logic signed [SUM_W-1:0]  sum_t;

	typedef struct packed {
		logic  ovf;
		word_t val;
	} sat_t;

	localparam word_t WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam word_t WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	function automatic sum_t ext_prod(input prod_t p);
		return {{(SUM_W-PROD_W){p[PROD_W-1]}}, p};
	endfunction

	function automatic sum_t ext_add(input add_t p);
		return {{(SUM_W-ADD_W){p[ADD_W-1]}}, p};
	endfunction

	function automatic sum_t ext_word(input word_t p);
		return {{(SUM_W-DATA_W){p[DATA_W-1]}}, p};
	endfunction

	function automatic sat_t sat_word(input sum_t v);
		sat_t r;
		logic [SUM_W-DATA_W:0] hi;
		hi    = v[SUM_W-1:DATA_W-1];
		r.ovf = !((&hi) || (~|hi));
		if (!r.ovf) begin
			r.val = v[DATA_W-1:0];
		end else if (v[SUM_W-1]) begin
			r.val = WORD_MIN;
		end else begin
			r.val = WORD_MAX;
		end
		return r;
	endfunction

endpackage

>>> rtl/core/qau_mul_lane.sv
// One signed Q8.24 multiplier lane with truncating shift and output register
module qau_mul_lane (
	input  logic          clk,
	input  logic          en,
	input  qau_pkg::word_t op_a,
	input  qau_pkg::word_t op_b,
	input  logic          dbl,
	output qau_pkg::prod_t prod
);

	logic signed [qau_pkg::FULL_W-1:0] full;
	qau_pkg::prod_t                    prod_s1;

	assign full = op_a * op_b;

	always_ff @(posedge clk) begin
		if (en) begin
			if (dbl) begin
				prod_s1 <= full[qau_pkg::FULL_W-1:qau_pkg::TWICE_SHIFT];
			end else begin
				prod_s1 <= {full[qau_pkg::FULL_W-1],
					full[qau_pkg::FULL_W-1:qau_pkg::FRAC_BITS]};
			end
		end
	end

	assign prod = prod_s1;

endmodule

>>> rtl/core/quaternion_arithmetic_unit.sv
// Quaternion arithmetic unit: product, vector rotation, sum and difference in Q8.24.
// Pipeline: each accepted input beat passes through every registered stage in turn to become its result beat.
// Throughput: one beat per cycle; stalls back up stage by stage and bubbles are squeezed out.
// Reset: arst_n clears all stage valid bits at once; data registers are not reset.
`include "quaternion_arithmetic_unit_defines.svh"

module quaternion_arithmetic_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_stall,
	input  logic [1:0]     func,
	input  qau_pkg::word_t a_w,
	input  qau_pkg::word_t a_x,
	input  qau_pkg::word_t a_y,
	input  qau_pkg::word_t a_z,
	input  qau_pkg::word_t b_w,
	input  qau_pkg::word_t b_x,
	input  qau_pkg::word_t b_y,
	input  qau_pkg::word_t b_z,
	output logic           res_valid,
	input  logic           res_stall,
	output qau_pkg::word_t res_w,
	output qau_pkg::word_t res_x,
	output qau_pkg::word_t res_y,
	output qau_pkg::word_t res_z,
	output logic           overflow
);

	localparam int NP = qau_pkg::N_PROD;
	localparam int NB = qau_pkg::N_BASIS;
	localparam int NC = qau_pkg::N_COMP;
	localparam int NV = qau_pkg::N_VEC;

	logic rdy1, rdy2, rdy3, rdy4, rdy5;
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;

	// stage 1: operand routing and add/sub
	qau_pkg::func_t func_c;
	qau_pkg::word_t opa_c [NP];
	qau_pkg::word_t opb_c [NP];
	logic           dbl_c [NP];
	qau_pkg::add_t  addsub_c [NC];
	qau_pkg::word_t a_c [NC];
	qau_pkg::word_t b_c [NC];

	qau_pkg::func_t func_s1;
	qau_pkg::word_t opa_s1 [NP];
	qau_pkg::word_t opb_s1 [NP];
	logic           dbl_s1 [NP];
	qau_pkg::add_t  addsub_s1 [NC];
	qau_pkg::word_t bvec_s1 [NV];

	// stage 2: products
	qau_pkg::func_t func_s2;
	qau_pkg::prod_t prod_s2 [NP];
	qau_pkg::add_t  addsub_s2 [NC];
	qau_pkg::word_t bvec_s2 [NV];

	// stage 3: sums and basis
	qau_pkg::sum_t  pre3_c [NB];
	qau_pkg::sat_t  sat3_c [NB];
	qau_pkg::sum_t  t_c [NP];
	logic           ovf3_c;

	qau_pkg::func_t func_s3;
	qau_pkg::word_t comp_s3 [NB];
	logic           ovf_s3;
	qau_pkg::word_t bvec_s3 [NV];

	// stage 4: basis weighting
	qau_pkg::func_t func_s4;
	qau_pkg::prod_t m_s4 [NB];
	qau_pkg::word_t res_s4 [NC];
	logic           ovf_s4;

	// stage 5: result
	qau_pkg::sum_t  pre5_c [NC];
	qau_pkg::sat_t  sat5_c [NC];
	logic           ovf5_c;

	qau_pkg::func_t func_s5;
	qau_pkg::word_t res_s5 [NC];
	logic           ovf_s5;
	logic           sat_seen_c;

	assign rdy5 = !valid_s5 || !res_stall;
	assign rdy4 = !valid_s4 || rdy5;
	assign rdy3 = !valid_s3 || rdy4;
	assign rdy2 = !valid_s2 || rdy3;
	assign rdy1 = !valid_s1 || rdy2;
	assign item_stall = !rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (rdy1) begin
				valid_s1 <= item_valid;
			end
			if (rdy2) begin
				valid_s2 <= valid_s1;
			end
			if (rdy3) begin
				valid_s3 <= valid_s2;
			end
			if (rdy4) begin
				valid_s4 <= valid_s3;
			end
			if (rdy5) begin
				valid_s5 <= valid_s4;
			end
		end
	end

	assign func_c = qau_pkg::func_t'(func);
	assign a_c[0] = a_w;
	assign a_c[1] = a_x;
	assign a_c[2] = a_y;
	assign a_c[3] = a_z;
	assign b_c[0] = b_w;
	assign b_c[1] = b_x;
	assign b_c[2] = b_y;
	assign b_c[3] = b_z;

	always_comb begin
		for (int k = 0; k < NP; k++) begin
			opa_c[k] = '0;
			opb_c[k] = '0;
			dbl_c[k] = 1'b0;
		end
		case (func_c)
			qau_pkg::FUNC_ROT: begin
				opa_c[0] = a_w;  opb_c[0] = a_w;
				opa_c[1] = a_x;  opb_c[1] = a_x;
				opa_c[2] = a_y;  opb_c[2] = a_y;
				opa_c[3] = a_z;  opb_c[3] = a_z;
				opa_c[4] = a_w;  opb_c[4] = a_x;  dbl_c[4] = 1'b1;
				opa_c[5] = a_w;  opb_c[5] = a_y;  dbl_c[5] = 1'b1;
				opa_c[6] = a_w;  opb_c[6] = a_z;  dbl_c[6] = 1'b1;
				opa_c[7] = a_x;  opb_c[7] = a_y;  dbl_c[7] = 1'b1;
				opa_c[8] = a_x;  opb_c[8] = a_z;  dbl_c[8] = 1'b1;
				opa_c[9] = a_y;  opb_c[9] = a_z;  dbl_c[9] = 1'b1;
			end
			default: begin
				opa_c[0]  = a_w;  opb_c[0]  = b_w;
				opa_c[1]  = a_x;  opb_c[1]  = b_x;
				opa_c[2]  = a_y;  opb_c[2]  = b_y;
				opa_c[3]  = a_z;  opb_c[3]  = b_z;
				opa_c[4]  = a_w;  opb_c[4]  = b_x;
				opa_c[5]  = b_w;  opb_c[5]  = a_x;
				opa_c[6]  = a_y;  opb_c[6]  = b_z;
				opa_c[7]  = a_z;  opb_c[7]  = b_y;
				opa_c[8]  = a_w;  opb_c[8]  = b_y;
				opa_c[9]  = b_w;  opb_c[9]  = a_y;
				opa_c[10] = a_z;  opb_c[10] = b_x;
				opa_c[11] = a_x;  opb_c[11] = b_z;
				opa_c[12] = a_w;  opb_c[12] = b_z;
				opa_c[13] = b_w;  opb_c[13] = a_z;
				opa_c[14] = a_x;  opb_c[14] = b_y;
				opa_c[15] = a_y;  opb_c[15] = b_x;
			end
		endcase
		for (int k = 0; k < NC; k++) begin
			if (func_c == qau_pkg::FUNC_SUB) begin
				addsub_c[k] = {a_c[k][qau_pkg::DATA_W-1], a_c[k]} -
					{b_c[k][qau_pkg::DATA_W-1], b_c[k]};
			end else begin
				addsub_c[k] = {a_c[k][qau_pkg::DATA_W-1], a_c[k]} +
					{b_c[k][qau_pkg::DATA_W-1], b_c[k]};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			func_s1 <= func_c;
			for (int k = 0; k < NP; k++) begin
				opa_s1[k] <= opa_c[k];
				opb_s1[k] <= opb_c[k];
				dbl_s1[k] <= dbl_c[k];
			end
			for (int k = 0; k < NC; k++) begin
				addsub_s1[k] <= addsub_c[k];
			end
			for (int k = 0; k < NV; k++) begin
				bvec_s1[k] <= b_c[k+1];
			end
		end
	end

	for (genvar g = 0; g < NP; g++) begin : g_prod
		qau_mul_lane u_lane (
			.clk  (clk),
			.en   (rdy2),
			.op_a (opa_s1[g]),
			.op_b (opb_s1[g]),
			.dbl  (dbl_s1[g]),
			.prod (prod_s2[g])
		);
	end

	always_ff @(posedge clk) begin
		if (rdy2) begin
			func_s2 <= func_s1;
			for (int k = 0; k < NC; k++) begin
				addsub_s2[k] <= addsub_s1[k];
			end
			for (int k = 0; k < NV; k++) begin
				bvec_s2[k] <= bvec_s1[k];
			end
		end
	end

	always_comb begin
		for (int k = 0; k < NP; k++) begin
			t_c[k] = qau_pkg::ext_prod(prod_s2[k]);
		end
		for (int k = 0; k < NB; k++) begin
			pre3_c[k] = '0;
		end
		case (func_s2)
			qau_pkg::FUNC_MUL: begin
				pre3_c[0] = t_c[0] - t_c[1] - t_c[2] - t_c[3];
				pre3_c[1] = t_c[4] + t_c[5] + t_c[6] - t_c[7];
				pre3_c[2] = t_c[8] + t_c[9] + t_c[10] - t_c[11];
				pre3_c[3] = t_c[12] + t_c[13] + t_c[14] - t_c[15];
			end
			qau_pkg::FUNC_ROT: begin
				// t: ww xx yy zz wx wy wz xy xz yz
				pre3_c[0] = t_c[0] + t_c[1] - t_c[2] - t_c[3];
				pre3_c[1] = t_c[6] + t_c[7];
				pre3_c[2] = t_c[8] - t_c[5];
				pre3_c[3] = t_c[7] - t_c[6];
				pre3_c[4] = t_c[0] - t_c[1] + t_c[2] - t_c[3];
				pre3_c[5] = t_c[4] + t_c[9];
				pre3_c[6] = t_c[5] + t_c[8];
				pre3_c[7] = t_c[9] - t_c[4];
				pre3_c[8] = t_c[0] - t_c[1] - t_c[2] + t_c[3];
			end
			default: begin
				for (int k = 0; k < NC; k++) begin
					pre3_c[k] = qau_pkg::ext_add(addsub_s2[k]);
				end
			end
		endcase
		ovf3_c = 1'b0;
		for (int k = 0; k < NB; k++) begin
			sat3_c[k] = qau_pkg::sat_word(pre3_c[k]);
			ovf3_c    = ovf3_c | sat3_c[k].ovf;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3) begin
			func_s3 <= func_s2;
			ovf_s3  <= ovf3_c;
			for (int k = 0; k < NB; k++) begin
				comp_s3[k] <= sat3_c[k].val;
			end
			for (int k = 0; k < NV; k++) begin
				bvec_s3[k] <= bvec_s2[k];
			end
		end
	end

	// basis order: ux uy uz vx vy vz nx ny nz, weighted by bx, by, bz
	for (genvar g = 0; g < NB; g++) begin : g_basis
		qau_mul_lane u_lane (
			.clk  (clk),
			.en   (rdy4),
			.op_a (comp_s3[g]),
			.op_b (bvec_s3[g/NV]),
			.dbl  (1'b0),
			.prod (m_s4[g])
		);
	end

	always_ff @(posedge clk) begin
		if (rdy4) begin
			func_s4 <= func_s3;
			ovf_s4  <= ovf_s3;
			for (int k = 0; k < NC; k++) begin
				res_s4[k] <= comp_s3[k];
			end
		end
	end

	always_comb begin
		if (func_s4 == qau_pkg::FUNC_ROT) begin
			pre5_c[0] = '0;
			for (int k = 0; k < NV; k++) begin
				pre5_c[k+1] = qau_pkg::ext_prod(m_s4[k]) +
					qau_pkg::ext_prod(m_s4[k+NV]) +
					qau_pkg::ext_prod(m_s4[k+2*NV]);
			end
		end else begin
			for (int k = 0; k < NC; k++) begin
				pre5_c[k] = qau_pkg::ext_word(res_s4[k]);
			end
		end
		ovf5_c = ovf_s4;
		for (int k = 0; k < NC; k++) begin
			sat5_c[k] = qau_pkg::sat_word(pre5_c[k]);
			ovf5_c    = ovf5_c | sat5_c[k].ovf;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy5) begin
			func_s5 <= func_s4;
			ovf_s5  <= ovf5_c;
			for (int k = 0; k < NC; k++) begin
				res_s5[k] <= sat5_c[k].val;
			end
		end
	end

	assign res_valid = valid_s5;
	assign res_w     = res_s5[0];
	assign res_x     = res_s5[1];
	assign res_y     = res_s5[2];
	assign res_z     = res_s5[3];
	assign overflow  = ovf_s5;

	always_comb begin
		sat_seen_c = 1'b0;
		for (int k = 0; k < NC; k++) begin
			sat_seen_c = sat_seen_c || (res_s5[k] == qau_pkg::WORD_MAX) ||
				(res_s5[k] == qau_pkg::WORD_MIN);
		end
	end

	`QAU_ASSERT_IMPL(a_stall_needs_s1, clk, arst_n, item_stall, valid_s1, "input stalled with stage 1 empty")
	`QAU_ASSERT_NEXT(a_s4_to_s5, clk, arst_n, valid_s4 && rdy4, valid_s5, "beat lost between stages 4 and 5")
	`QAU_ASSERT_NEXT(a_s2_hold, clk, arst_n, valid_s2 && !rdy2, valid_s2 && $stable(func_s2), "stage 2 beat not held under stall")
	`QAU_ASSERT_IMPL(a_ovf_clamped, clk, arst_n, valid_s5 && ovf_s5 && (func_s5 != qau_pkg::FUNC_ROT), sat_seen_c, "overflow without a clamped component")
	`QAU_ASSERT_IMPL(a_rot_w_zero, clk, arst_n, valid_s5 && (func_s5 == qau_pkg::FUNC_ROT), res_s5[0] == '0, "rotate result with nonzero scalar")

endmodule

>>> tb/quaternion_arithmetic_unit_tb.sv
// Self-checking testbench for the Q8.24 quaternion arithmetic unit
module quaternion_arithmetic_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import qau_pkg::*;

	localparam int   ONE_Q     = 1 << 24;
	localparam int   IDLE_PCT  = 28;

	typedef struct {
		func_t op;
		word_t aw, ax, ay, az;
		word_t bw, bx, by, bz;
	} quat_beat_t;

	typedef struct {
		word_t w, x, y, z;
		logic  ovf;
	} quat_res_t;

	logic       clk;
	logic       arst_n;
	logic       item_valid;
	logic       item_stall;
	logic [1:0] func;
	word_t      a_w, a_x, a_y, a_z;
	word_t      b_w, b_x, b_y, b_z;
	logic       res_valid;
	logic       res_stall;
	word_t      res_w, res_x, res_y, res_z;
	logic       overflow;

	quat_res_t  pending_results[$];
	int         err_count;
	int         hold_left;
	bit         tx_idle_on;
	bit         rx_idle_on;

	quaternion_arithmetic_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.func       (func),
		.a_w        (a_w),
		.a_x        (a_x),
		.a_y        (a_y),
		.a_z        (a_z),
		.b_w        (b_w),
		.b_x        (b_x),
		.b_y        (b_y),
		.b_z        (b_z),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res_w      (res_w),
		.res_x      (res_x),
		.res_y      (res_y),
		.res_z      (res_z),
		.overflow   (overflow)
	);

	function automatic longint qmul(input longint s, input longint t);
		return (s * t) >>> 24;
	endfunction

	function automatic longint qmul2(input longint s, input longint t);
		return (s * t) >>> 23;
	endfunction

	function automatic word_t clamp(input longint v, inout logic ovf);
		if (v > longint'(WORD_MAX)) begin
			ovf = 1'b1;
			return WORD_MAX;
		end
		if (v < longint'(WORD_MIN)) begin
			ovf = 1'b1;
			return WORD_MIN;
		end
		return word_t'(v);
	endfunction

	function automatic quat_res_t quat_compute(input quat_beat_t t);
		longint    aw, ax, ay, az, bw, bx, by, bz;
		longint    r0, r1, r2, r3;
		longint    ww, xx, yy, zz, wx, wy, wz, xy, xz, yz;
		longint    ux, uy, uz, vx, vy, vz, nx, ny, nz;
		logic      ovf;
		quat_res_t e;
		aw = t.aw; ax = t.ax; ay = t.ay; az = t.az;
		bw = t.bw; bx = t.bx; by = t.by; bz = t.bz;
		ovf = 1'b0;
		case (t.op)
			FUNC_MUL: begin
				r0 = qmul(aw, bw) - qmul(ax, bx) - qmul(ay, by) - qmul(az, bz);
				r1 = qmul(aw, bx) + qmul(bw, ax) + qmul(ay, bz) - qmul(az, by);
				r2 = qmul(aw, by) + qmul(bw, ay) + qmul(az, bx) - qmul(ax, bz);
				r3 = qmul(aw, bz) + qmul(bw, az) + qmul(ax, by) - qmul(ay, bx);
			end
			FUNC_ROT: begin
				ww = qmul(aw, aw);  xx = qmul(ax, ax);
				yy = qmul(ay, ay);  zz = qmul(az, az);
				wx = qmul2(aw, ax); wy = qmul2(aw, ay); wz = qmul2(aw, az);
				xy = qmul2(ax, ay); xz = qmul2(ax, az); yz = qmul2(ay, az);
				ux = clamp(ww + xx - yy - zz, ovf);
				uy = clamp(wz + xy, ovf);
				uz = clamp(xz - wy, ovf);
				vx = clamp(xy - wz, ovf);
				vy = clamp(ww - xx + yy - zz, ovf);
				vz = clamp(wx + yz, ovf);
				nx = clamp(wy + xz, ovf);
				ny = clamp(yz - wx, ovf);
				nz = clamp(ww - xx - yy + zz, ovf);
				r0 = 0;
				r1 = qmul(ux, bx) + qmul(vx, by) + qmul(nx, bz);
				r2 = qmul(uy, bx) + qmul(vy, by) + qmul(ny, bz);
				r3 = qmul(uz, bx) + qmul(vz, by) + qmul(nz, bz);
			end
			FUNC_ADD: begin
				r0 = aw + bw; r1 = ax + bx; r2 = ay + by; r3 = az + bz;
			end
			default: begin
				r0 = aw - bw; r1 = ax - bx; r2 = ay - by; r3 = az - bz;
			end
		endcase
		e.w = clamp(r0, ovf);
		e.x = clamp(r1, ovf);
		e.y = clamp(r2, ovf);
		e.z = clamp(r3, ovf);
		e.ovf = ovf;
		return e;
	endfunction

	function automatic quat_beat_t mk(input func_t op,
			input word_t aw, input word_t ax, input word_t ay, input word_t az,
			input word_t bw, input word_t bx, input word_t by, input word_t bz);
		quat_beat_t t;
		t.op = op;
		t.aw = aw; t.ax = ax; t.ay = ay; t.az = az;
		t.bw = bw; t.bx = bx; t.by = by; t.bz = bz;
		return t;
	endfunction

	function automatic word_t rand_word();
		case ($urandom_range(9))
			0:       return WORD_MAX;
			1:       return WORD_MIN;
			2:       return word_t'(0);
			3, 4, 5: return word_t'($urandom_range(0, 1 << 26) - (1 << 25));
			6, 7:    return word_t'($urandom);
			8:       return $urandom_range(1) ? word_t'(ONE_Q) : word_t'(-ONE_Q);
			default: return word_t'($urandom_range(0, 510) - 255);
		endcase
	endfunction

	function automatic word_t rand_unitish();
		return word_t'($urandom_range(0, 2 * ONE_Q) - ONE_Q);
	endfunction

	function automatic quat_beat_t rand_beat(input func_t op);
		quat_beat_t t;
		t = mk(op, rand_word(), rand_word(), rand_word(), rand_word(),
			rand_word(), rand_word(), rand_word(), rand_word());
		if (op == FUNC_ROT && $urandom_range(99) < 70) begin
			t.aw = rand_unitish(); t.ax = rand_unitish();
			t.ay = rand_unitish(); t.az = rand_unitish();
			t.bx = word_t'($urandom_range(0, 1 << 28) - (1 << 27));
			t.by = word_t'($urandom_range(0, 1 << 28) - (1 << 27));
			t.bz = word_t'($urandom_range(0, 1 << 28) - (1 << 27));
		end
		return t;
	endfunction

	task automatic send_beat(input quat_beat_t t);
		if (tx_idle_on) begin
			while ($urandom_range(99) < IDLE_PCT) begin
				item_valid <= 1'b0;
				@(posedge clk);
			end
		end
		item_valid <= 1'b1;
		func <= t.op;
		a_w <= t.aw; a_x <= t.ax; a_y <= t.ay; a_z <= t.az;
		b_w <= t.bw; b_x <= t.bx; b_y <= t.by; b_z <= t.bz;
		do @(posedge clk); while (item_stall);
		pending_results.push_back(quat_compute(t));
	endtask

	task automatic wait_drained();
		item_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic flag_field(input string field, input longint want, input longint got);
		err_count++;
		$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
	endtask

	always @(posedge clk) begin
		quat_res_t e;
		if (arst_n && res_valid && !res_stall) begin
			if (pending_results.size() == 0) begin
				err_count++;
				$display("%0t: unexpected result beat, expected none, got w=%0d x=%0d y=%0d z=%0d",
					$time, res_w, res_x, res_y, res_z);
			end else begin
				e = pending_results.pop_front();
				if (res_w !== e.w) flag_field("res_w", e.w, res_w);
				if (res_x !== e.x) flag_field("res_x", e.x, res_x);
				if (res_y !== e.y) flag_field("res_y", e.y, res_y);
				if (res_z !== e.z) flag_field("res_z", e.z, res_z);
				if (overflow !== e.ovf) flag_field("overflow", e.ovf, overflow);
			end
		end
	end

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		res_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				res_stall <= 1'b1;
				hold_left--;
			end else if (rx_idle_on) begin
				res_stall <= ($urandom_range(99) < IDLE_PCT);
			end else begin
				res_stall <= 1'b0;
			end
		end
	end

	initial begin
		#2ms;
		$display("quaternion_arithmetic_unit_tb NOT OK");
		$finish;
	end

	task automatic test_corner_cases();
		word_t h;
		h = word_t'(11863283);
		send_beat(mk(FUNC_MUL, 0, 0, 0, 0, 0, 0, 0, 0));
		send_beat(mk(FUNC_MUL, ONE_Q, 0, 0, 0, 123456, -7654321, 33554432, -1));
		send_beat(mk(FUNC_MUL, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX,
			WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX));
		send_beat(mk(FUNC_MUL, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN,
			WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN));
		send_beat(mk(FUNC_MUL, -1, 0, 0, 0, 1, 0, 0, 0));
		send_beat(mk(FUNC_MUL, 3, -5, 7, -9, 1 << 23, -(1 << 22), 1, -1));
		send_beat(mk(FUNC_ROT, ONE_Q, 0, 0, 0, 999, 25165824, -37748736, 8388608));
		send_beat(mk(FUNC_ROT, h, 0, 0, h, WORD_MIN, ONE_Q, 2 * ONE_Q, -ONE_Q));
		send_beat(mk(FUNC_ROT, 0, ONE_Q, 0, 0, 0, ONE_Q, ONE_Q, ONE_Q));
		send_beat(mk(FUNC_ROT, 2 * ONE_Q, 0, 0, 0, 0, ONE_Q, -ONE_Q, 3));
		send_beat(mk(FUNC_ROT, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX,
			WORD_MAX, 1000, -1000, 1));
		send_beat(mk(FUNC_ROT, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN,
			0, WORD_MIN, WORD_MIN, WORD_MIN));
		send_beat(mk(FUNC_ROT, -1, 1, -1, 1, 0, ONE_Q, ONE_Q, -ONE_Q));
		send_beat(mk(FUNC_ROT, ONE_Q, -ONE_Q, ONE_Q, -ONE_Q,
			WORD_MAX, WORD_MAX, WORD_MIN, WORD_MAX));
		send_beat(mk(FUNC_ADD, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX,
			WORD_MAX, 1, 0, -1));
		send_beat(mk(FUNC_ADD, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN,
			WORD_MIN, -1, 0, 1));
		send_beat(mk(FUNC_ADD, WORD_MAX, WORD_MIN, 5, -5, WORD_MIN, WORD_MAX, -5, 5));
		send_beat(mk(FUNC_SUB, WORD_MIN, WORD_MIN, 0, -1, WORD_MAX, 1, WORD_MIN, WORD_MAX));
		send_beat(mk(FUNC_SUB, WORD_MAX, WORD_MAX, 0, 0, WORD_MIN, -1, WORD_MAX, 0));
		send_beat(mk(FUNC_SUB, ONE_Q, -ONE_Q, 12345, -67890, -ONE_Q, ONE_Q, 12345, 1));
		wait_drained();
	endtask

	task automatic test_product();
		repeat (300) send_beat(rand_beat(FUNC_MUL));
	endtask

	task automatic test_rotate();
		repeat (300) send_beat(rand_beat(FUNC_ROT));
	endtask

	task automatic test_add_sub();
		repeat (200) send_beat(rand_beat(func_t'($urandom_range(FUNC_ADD, FUNC_SUB))));
		wait_drained();
	endtask

	task automatic test_back_pressure();
		tx_idle_on = 1'b0;
		hold_left = 80;
		repeat (60) send_beat(rand_beat(func_t'($urandom_range(3))));
		tx_idle_on = 1'b1;
		wait_drained();
	endtask

	task automatic test_full_rate();
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		repeat (300) send_beat(rand_beat(func_t'($urandom_range(3))));
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
	endtask

	task automatic test_mixed();
		repeat (300) send_beat(rand_beat(func_t'($urandom_range(3))));
	endtask

	initial begin
		arst_n     = 1'b0;
		item_valid = 1'b0;
		func       = FUNC_MUL;
		a_w = '0; a_x = '0; a_y = '0; a_z = '0;
		b_w = '0; b_x = '0; b_y = '0; b_z = '0;
		err_count  = 0;
		hold_left  = 0;
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_corner_cases();
		test_product();
		test_rotate();
		test_add_sub();
		test_back_pressure();
		test_full_rate();
		test_mixed();
		wait_drained();
		repeat (10) @(posedge clk);
		if (err_count == 0 && pending_results.size() == 0) begin
			$display("quaternion_arithmetic_unit_tb OK");
		end else begin
			$display("quaternion_arithmetic_unit_tb NOT OK");
		end
		$finish;
	end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/qau_pkg.sv
rtl/core/qau_mul_lane.sv
rtl/core/quaternion_arithmetic_unit.sv
tb/quaternion_arithmetic_unit_tb.sv
